// File: src/b40d_pkg.sv
// Shared constants, types and the digit-to-character map of the base-40 decoder.
`timescale 1ns / 1ps
`default_nettype none

package b40d_pkg;

  localparam int unsigned NUM_CHARS = 12;   // decoded character positions, 1..12
  localparam int unsigned OUT_CHARS = 12;   // character fields on the result
  localparam int unsigned WORD_W    = 64;
  localparam int unsigned CHAR_W    = 7;
  localparam int unsigned DIGIT_W   = 6;
  localparam int unsigned CHUNK_W   = 16;
  localparam int unsigned CHUNKS    = WORD_W / CHUNK_W;
  localparam int unsigned PHASE_W   = $clog2(CHUNKS);
  localparam int unsigned STAGES    = NUM_CHARS * CHUNKS;

  // One long-division step divides {remainder, chunk} by the radix.
  localparam int unsigned PART_W    = DIGIT_W + CHUNK_W;
  localparam int unsigned EIGHTH_W  = PART_W - 3;
  // The radix is 8 * 5; floor(y / 5) = (y * RECIP_5) >> RECIP_SHIFT for y < 2**19.
  localparam int unsigned RECIP_W     = 20;
  localparam int unsigned RECIP_SHIFT = 22;
  localparam logic [RECIP_W-1:0] RECIP_5 = 20'd838861;
  localparam int unsigned PROD_W    = EIGHTH_W + RECIP_W;

  localparam logic [PHASE_W-1:0] LAST_PHASE = PHASE_W'(CHUNKS - 1);

  localparam logic [CHAR_W-1:0] CHAR_NUL   = 7'h00;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 7'h20;
  localparam logic [CHAR_W-1:0] CHAR_DASH  = 7'h2D;
  localparam logic [CHAR_W-1:0] CHAR_SLASH = 7'h2F;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_A     = 7'h41;
  localparam logic [CHAR_W-1:0] CHAR_UNDER = 7'h5F;

  localparam logic [DIGIT_W-1:0] DIG_SPACE = 6'd0;
  localparam logic [DIGIT_W-1:0] DIG_DASH  = 6'd1;
  localparam logic [DIGIT_W-1:0] DIG_SLASH = 6'd2;
  localparam logic [DIGIT_W-1:0] DIG_ZERO  = 6'd3;
  localparam logic [DIGIT_W-1:0] DIG_A     = 6'd13;
  localparam logic [DIGIT_W-1:0] DIG_UNDER = 6'd39;

  typedef logic [OUT_CHARS-1:0][CHAR_W-1:0] char_vec_t;

  // Everything an item carries from one cell to the next.
  typedef struct packed {
    logic [WORD_W-1:0]  word;   // dividend, turning into the quotient chunk by chunk
    logic [DIGIT_W-1:0] rem;    // running remainder of the current digit
    logic [PHASE_W-1:0] phase;  // chunk being divided within the current digit
    char_vec_t          chars;  // characters decoded so far
  } lane_t;

  function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d == DIG_UNDER) begin
      c = CHAR_UNDER;
    end else if (d >= DIG_A) begin
      c = CHAR_A + CHAR_W'(d - DIG_A);
    end else if (d >= DIG_ZERO) begin
      c = CHAR_ZERO + CHAR_W'(d - DIG_ZERO);
    end else if (d == DIG_SLASH) begin
      c = CHAR_SLASH;
    end else if (d == DIG_DASH) begin
      c = CHAR_DASH;
    end else begin
      c = CHAR_SPACE;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: src/b40d_in_if.sv
// Input channel: one packed identifier per item.
`timescale 1ns / 1ps
`default_nettype none

interface b40d_in_if
  import b40d_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] packed_id;

  modport source (output valid, output packed_id, input ready);
  modport sink (input valid, input packed_id, output ready);
endinterface

`default_nettype wire

// File: src/b40d_out_if.sv
// Output channel: twelve decoded characters per item.
`timescale 1ns / 1ps
`default_nettype none

interface b40d_out_if
  import b40d_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_0;
  logic [CHAR_W-1:0] char_1;
  logic [CHAR_W-1:0] char_2;
  logic [CHAR_W-1:0] char_3;
  logic [CHAR_W-1:0] char_4;
  logic [CHAR_W-1:0] char_5;
  logic [CHAR_W-1:0] char_6;
  logic [CHAR_W-1:0] char_7;
  logic [CHAR_W-1:0] char_8;
  logic [CHAR_W-1:0] char_9;
  logic [CHAR_W-1:0] char_10;
  logic [CHAR_W-1:0] char_11;

  modport source (
    output valid, input ready,
    output char_0, output char_1, output char_2, output char_3,
    output char_4, output char_5, output char_6, output char_7,
    output char_8, output char_9, output char_10, output char_11
  );
  modport sink (
    input valid, output ready,
    input char_0, input char_1, input char_2, input char_3,
    input char_4, input char_5, input char_6, input char_7,
    input char_8, input char_9, input char_10, input char_11
  );
endinterface

`default_nettype wire

// File: src/b40d_cell.sv
// One division cell: divides the top 16-bit chunk by 40 and rotates the word.
`timescale 1ns / 1ps
`default_nettype none

module b40d_cell
  import b40d_pkg::*;
(
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        valid_i,
  output logic       ready_o,
  input  wire lane_t lane_i,
  output logic       valid_o,
  input  wire        ready_i,
  output lane_t      lane_o
);

  logic                valid_q;
  lane_t               lane_q;
  lane_t               lane_d;
  logic [PART_W-1:0]   part;
  logic [PROD_W-1:0]   prod;
  logic [CHUNK_W-1:0]  quot;
  logic [PART_W-1:0]   quot_x40;
  logic [DIGIT_W-1:0]  rem_new;

  always_comb begin
    part     = {lane_i.rem, lane_i.word[WORD_W-1 -: CHUNK_W]};
    prod     = PROD_W'(part[PART_W-1:3]) * PROD_W'(RECIP_5);
    quot     = prod[RECIP_SHIFT +: CHUNK_W];
    quot_x40 = (PART_W'(quot) << 5) + (PART_W'(quot) << 3);
    rem_new  = DIGIT_W'(part - quot_x40);

    lane_d       = lane_i;
    // The quotient chunk replaces the dividend chunk; after all chunks the
    // word is back in its original order and holds the full quotient.
    lane_d.word  = {lane_i.word[WORD_W-CHUNK_W-1:0], quot};
    lane_d.phase = lane_i.phase + PHASE_W'(1);
    if (lane_i.phase == LAST_PHASE) begin
      // The final remainder is the digit. Earlier digits move up one position.
      lane_d.rem   = '0;
      lane_d.chars = {lane_i.chars[OUT_CHARS-2:0], digit_to_char(rem_new)};
    end else begin
      lane_d.rem = rem_new;
    end
  end

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign lane_o  = lane_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      lane_q <= lane_d;
    end
  end

endmodule

`default_nettype wire

// File: src/b40d_trim.sv
// Output stage: clears trailing spaces and holds the result for the consumer.
`timescale 1ns / 1ps
`default_nettype none

module b40d_trim
  import b40d_pkg::*;
(
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            valid_i,
  output logic           ready_o,
  input  wire char_vec_t chars_i,
  b40d_out_if.source     out_o
);

  logic      valid_q;
  char_vec_t chars_q;
  char_vec_t chars_d;
  logic      seen;

  // Scan down from the last decoded position; everything above the last
  // non-space character becomes NUL. Unused positions are already NUL.
  always_comb begin
    seen = 1'b0;
    for (int i = OUT_CHARS - 1; i >= 0; i--) begin
      if (i < NUM_CHARS && chars_i[i] != CHAR_SPACE) begin
        seen = 1'b1;
      end
      chars_d[i] = seen ? chars_i[i] : CHAR_NUL;
    end
  end

  assign ready_o = !valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      chars_q <= chars_d;
    end
  end

  assign out_o.valid   = valid_q;
  assign out_o.char_0  = chars_q[0];
  assign out_o.char_1  = chars_q[1];
  assign out_o.char_2  = chars_q[2];
  assign out_o.char_3  = chars_q[3];
  assign out_o.char_4  = chars_q[4];
  assign out_o.char_5  = chars_q[5];
  assign out_o.char_6  = chars_q[6];
  assign out_o.char_7  = chars_q[7];
  assign out_o.char_8  = chars_q[8];
  assign out_o.char_9  = chars_q[9];
  assign out_o.char_10 = chars_q[10];
  assign out_o.char_11 = chars_q[11];

endmodule

`default_nettype wire

// File: src/base40_id_decoder.sv
// Top level of the base-40 identifier decoder: a chain of division cells and a trim stage.
`timescale 1ns / 1ps
`default_nettype none

// Decodes a 64-bit base-40 packed identifier into twelve ASCII characters,
// the most significant digit in char_0, with trailing spaces turned into NUL.
// The block accepts one item per clock cycle when the output is not
// stalled. Every digit takes four cells that each divide one 16-bit chunk by
// 40, 48 cells for twelve digits, followed by one output register that does
// the space trim; the first cell loads at the accepting edge. Each cell has
// its own valid bit and stalls only when it is full and its neighbor cannot
// take its item, so empty slots in the chain keep absorbing new items while
// a result waits.

module base40_id_decoder
  import b40d_pkg::*;
(
  input  wire        clk_i,
  input  wire        rst_ni,
  b40d_in_if.sink    in_i,
  b40d_out_if.source out_o
);

  logic  valid_s [STAGES+1];
  logic  ready_s [STAGES+1];
  lane_t lane_s  [STAGES+1];

  assign valid_s[0]       = in_i.valid;
  assign in_i.ready       = ready_s[0];
  assign lane_s[0].word   = in_i.packed_id;
  assign lane_s[0].rem    = '0;
  assign lane_s[0].phase  = '0;
  assign lane_s[0].chars  = '0;

  for (genvar s = 0; s < STAGES; s++) begin : g_cell
    b40d_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid_s[s]),
      .ready_o (ready_s[s]),
      .lane_i  (lane_s[s]),
      .valid_o (valid_s[s+1]),
      .ready_i (ready_s[s+1]),
      .lane_o  (lane_s[s+1])
    );
  end

  b40d_trim u_trim (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid_s[STAGES]),
    .ready_o (ready_s[STAGES]),
    .chars_i (lane_s[STAGES].chars),
    .out_o   (out_o)
  );

endmodule

`default_nettype wire

// File: test/tb_top.sv
// Self-checking testbench for the base-40 identifier decoder, with directed and random IDs.
`timescale 1ns / 1ps

module tb_top;
  import b40d_pkg::*;

  typedef logic [OUT_CHARS-1:0][CHAR_W-1:0] id_text_t;

  typedef struct {
    logic [WORD_W-1:0] id;
    bit                typed;
    id_text_t          want;
  } id_row_t;

  localparam int unsigned     RADIX        = 40;
  localparam logic [63:0]     ID_LIMIT     = 64'd16777216000000000000;  // 40**12
  localparam logic [63:0]     POW40_11     = 64'd419430400000000000;    // 40**11
  localparam int unsigned     BLOCKS       = 12;
  localparam int unsigned     BLOCK_ITEMS  = 100;
  localparam int unsigned     HOLD_CYCLES  = 200;
  localparam int unsigned     DRAIN_CYCLES = 80;
  localparam int unsigned     STALL_LIMIT  = 2000;
  localparam int unsigned     PRINT_LIMIT  = 40;

  // Stimulus table: an expected text is typed in where it is obvious.
  id_row_t dir_rows [18] = '{
    '{64'd0,  1'b1, {12{CHAR_NUL}}},
    '{64'd1,  1'b1, {CHAR_DASH, {11{CHAR_SPACE}}}},
    '{64'd2,  1'b1, {CHAR_SLASH, {11{CHAR_SPACE}}}},
    '{64'd3,  1'b1, {CHAR_ZERO, {11{CHAR_SPACE}}}},
    '{64'd12, 1'b1, {CHAR_ZERO + 7'd9, {11{CHAR_SPACE}}}},
    '{64'd13, 1'b1, {CHAR_A, {11{CHAR_SPACE}}}},
    '{64'd38, 1'b1, {CHAR_A + 7'd25, {11{CHAR_SPACE}}}},
    '{64'd39, 1'b1, {CHAR_UNDER, {11{CHAR_SPACE}}}},
    '{64'd40, 1'b0, '0},
    '{POW40_11, 1'b1, {{11{CHAR_NUL}}, CHAR_DASH}},
    '{64'd13 * POW40_11, 1'b1, {{11{CHAR_NUL}}, CHAR_A}},
    '{64'd13 * POW40_11 + 64'd13, 1'b1, {CHAR_A, {10{CHAR_SPACE}}, CHAR_A}},
    '{ID_LIMIT - 64'd1, 1'b1, {12{CHAR_UNDER}}},
    '{ID_LIMIT, 1'b1, {12{CHAR_NUL}}},
    '{64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '0},
    '{64'h8000_0000_0000_0000, 1'b0, '0},
    '{64'h5555_5555_5555_5555, 1'b0, '0},
    '{64'hAAAA_AAAA_AAAA_AAAA, 1'b0, '0}
  };

  logic clk = 1'b0;
  logic rst_n;

  b40d_in_if  in_ch ();
  b40d_out_if out_ch ();

  base40_id_decoder u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  id_text_t          expected_texts [$];
  logic [WORD_W-1:0] pending_ids [$];
  int unsigned       error_count = 0;
  bit                tx_idle = 1'b0;
  bit                rx_idle = 1'b0;
  bit                hold_req = 1'b0;

  function automatic logic [CHAR_W-1:0] digit_char(input int unsigned d);
    if (d == 39) return CHAR_UNDER;
    if (d >= 13) return CHAR_A + CHAR_W'(d - 13);
    if (d >= 3) return CHAR_ZERO + CHAR_W'(d - 3);
    if (d == 2) return CHAR_SLASH;
    if (d == 1) return CHAR_DASH;
    return CHAR_SPACE;
  endfunction

  // Expected characters for one identifier: digits fill from the last position back,
  // then the trailing run of spaces is cleared.
  function automatic id_text_t decode_id(input logic [WORD_W-1:0] id);
    id_text_t          txt;
    logic [WORD_W-1:0] v;
    int                n;
    int                k;
    txt = '0;
    v   = id;
    n   = (NUM_CHARS > OUT_CHARS) ? OUT_CHARS : ((NUM_CHARS < 1) ? 1 : int'(NUM_CHARS));
    for (k = n - 1; k >= 0; k--) begin
      txt[k] = digit_char(int'(v % RADIX));
      v      = v / RADIX;
    end
    for (k = n - 1; k >= 0 && txt[k] == CHAR_SPACE; k--) begin
      txt[k] = CHAR_NUL;
    end
    return txt;
  endfunction

  task automatic report_mismatch(input string msg);
    if (error_count < PRINT_LIMIT) $display("[%0t] mismatch: %s", $realtime, msg);
    error_count++;
  endtask

  // Entered and left at a falling edge; the expectation is queued at acceptance.
  task automatic send_id(input logic [WORD_W-1:0] id, input id_text_t want);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid     = 1'b1;
    in_ch.packed_id = id;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_texts.push_back(want);
    pending_ids.push_back(id);
    @(negedge clk);
  endtask

  // Result side: a random wait before each item when rx_idle is set, plus one long hold on request.
  initial begin
    int unsigned wait_cycles;
    bit          hold_done;
    hold_done    = 1'b0;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        out_ch.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end
      wait_cycles = rx_idle ? $urandom_range(0, 7) : 0;
      if (wait_cycles > 0) begin
        out_ch.ready = 1'b0;
        repeat (wait_cycles) @(negedge clk);
      end
      out_ch.ready = 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      @(negedge clk);
    end
  end

  id_text_t          got_text;
  id_text_t          want_text;
  logic [WORD_W-1:0] got_id;

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_ch.valid && out_ch.ready) begin
      got_text = {out_ch.char_11, out_ch.char_10, out_ch.char_9, out_ch.char_8,
                  out_ch.char_7, out_ch.char_6, out_ch.char_5, out_ch.char_4,
                  out_ch.char_3, out_ch.char_2, out_ch.char_1, out_ch.char_0};
      if (expected_texts.size() == 0) begin
        report_mismatch($sformatf("result %h with no identifier pending", got_text));
      end else begin
        want_text = expected_texts.pop_front();
        got_id    = pending_ids.pop_front();
        for (int k = 0; k < OUT_CHARS; k++) begin
          if (got_text[k] !== want_text[k]) begin
            report_mismatch($sformatf("id %h char_%0d: got %h, want %h",
                                      got_id, k, got_text[k], want_text[k]));
          end
        end
      end
    end
  end

  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    int unsigned       kind;
    int unsigned       len;
    int unsigned       d;
    logic [WORD_W-1:0] id;
    in_ch.valid     = 1'b0;
    in_ch.packed_id = '0;
    rst_n           = 1'b0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (dir_rows[r]) begin
      send_id(dir_rows[r].id, dir_rows[r].typed ? dir_rows[r].want : decode_id(dir_rows[r].id));
    end

    for (int blk = 0; blk < BLOCKS; blk++) begin
      tx_idle = blk[0];
      rx_idle = blk[1];
      if (blk == 3) begin
        // Let the whole pipeline drain before going on.
        in_ch.valid = 1'b0;
        while (expected_texts.size() != 0) @(negedge clk);
      end
      if (blk == 5) begin
        // Keep offering items while the result side holds off, so the chain fills up.
        tx_idle  = 1'b0;
        hold_req = 1'b1;
      end
      for (int i = 0; i < BLOCK_ITEMS; i++) begin
        kind = $urandom_range(0, 9);
        case (kind)
          0, 1, 2: id = {$urandom, $urandom};
          3, 4, 5, 6: begin
            // A short text with a space-filled tail and some spaces inside.
            len = $urandom_range(0, OUT_CHARS);
            id  = '0;
            for (int k = 0; k < OUT_CHARS; k++) begin
              if (k >= len) d = 0;
              else if ($urandom_range(0, 3) == 0) d = 0;
              else d = $urandom_range(0, RADIX - 1);
              id = id * RADIX + d;
            end
          end
          7: id = ID_LIMIT + ({$urandom, $urandom} % (~64'd0 - ID_LIMIT + 64'd1));
          8: id = 64'($urandom_range(0, RADIX * RADIX * RADIX));
          default: id = ~64'($urandom_range(0, 65535));
        endcase
        send_id(id, decode_id(id));
      end
    end

    in_ch.valid = 1'b0;
    while (expected_texts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
